// File: design/c2p_pkg.sv
// Shared types, constants and the arctangent table for the cartesian-to-polar core.
`timescale 1ns / 1ps

package c2p_pkg;

    // Port field widths
    localparam int COORD_WIDTH     = 16;
    localparam int MAG_WIDTH       = 16;
    localparam int OUT_ANGLE_WIDTH = 16;

    // Datapath formats
    localparam int CORDIC_FRAC    = 16;
    localparam int DATA_WIDTH     = COORD_WIDTH + CORDIC_FRAC + 3;
    localparam int ANGLE_WIDTH    = 32;
    localparam int ITERATIONS_DEF = 16;
    localparam int QUEUE_DEPTH    = 2;

    // 1/K in Q31, K being the converged rotation gain
    localparam logic [31:0] GAIN_Q31 = 32'h4DBA_76D4;
    // Magnitude scaling: Q31 gain and fractional datapath bits
    localparam int MAG_SHIFT = 31 + CORDIC_FRAC;

    localparam logic [ANGLE_WIDTH-1:0] ANGLE_PI    = 32'h8000_0000;
    localparam logic [ANGLE_WIDTH-1:0] ANGLE_ZERO  = 32'h0000_0000;
    localparam logic [ANGLE_WIDTH-1:0] ANGLE_ROUND = 32'h0000_8000;

    // Input request
    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] x_coord;
        logic signed [COORD_WIDTH-1:0] y_coord;
    } point_t;

    // Result
    typedef struct packed {
        logic [MAG_WIDTH-1:0]              magnitude;
        logic signed [OUT_ANGLE_WIDTH-1:0] angle;
    } polar_t;

    // Classified work item; axis points bypass the rotations
    typedef struct packed {
        logic                          special;
        logic signed [DATA_WIDTH-1:0]  x;
        logic signed [DATA_WIDTH-1:0]  y;
        logic [ANGLE_WIDTH-1:0]        z;
    } work_t;

    // atan(2^-idx) scaled so that 2^32 is a full turn, rounded to nearest
    function automatic logic [ANGLE_WIDTH-1:0] atan_entry(input logic [4:0] idx);
        logic [ANGLE_WIDTH-1:0] val;
        case (idx)
            5'd0:    val = 32'h2000_0000;
            5'd1:    val = 32'h12E4_051E;
            5'd2:    val = 32'h09FB_385B;
            5'd3:    val = 32'h0511_11D4;
            5'd4:    val = 32'h028B_0D43;
            5'd5:    val = 32'h0145_D7E1;
            5'd6:    val = 32'h00A2_F61E;
            5'd7:    val = 32'h0051_7C55;
            5'd8:    val = 32'h0028_BE53;
            5'd9:    val = 32'h0014_5F2F;
            5'd10:   val = 32'h000A_2F98;
            5'd11:   val = 32'h0005_17CC;
            5'd12:   val = 32'h0002_8BE6;
            5'd13:   val = 32'h0001_45F3;
            5'd14:   val = 32'h0000_A2FA;
            5'd15:   val = 32'h0000_517D;
            5'd16:   val = 32'h0000_28BE;
            5'd17:   val = 32'h0000_145F;
            5'd18:   val = 32'h0000_0A30;
            5'd19:   val = 32'h0000_0518;
            5'd20:   val = 32'h0000_028C;
            5'd21:   val = 32'h0000_0146;
            5'd22:   val = 32'h0000_00A3;
            5'd23:   val = 32'h0000_0051;
            5'd24:   val = 32'h0000_0029;
            5'd25:   val = 32'h0000_0014;
            5'd26:   val = 32'h0000_000A;
            5'd27:   val = 32'h0000_0005;
            5'd28:   val = 32'h0000_0003;
            5'd29:   val = 32'h0000_0001;
            5'd30:   val = 32'h0000_0001;
            default: val = 32'h0000_0000;
        endcase
        return val;
    endfunction

endpackage

// File: design/cartesian_to_polar_core.sv
// Cartesian-to-polar converter: one signed point in, rounded radius and angle out,
// computed by a fixed-point vectoring rotation pipeline. A new request is taken every
// cycle while point_stall is low; the accepting edge writes the input queue, then the
// request passes one register per micro-rotation, one for the gain multiply and one for
// the rounded result. The throughput of one request per cycle while nothing stalls is
// set by the fully unrolled rotation pipeline; point_stall rises only when the two-entry
// input queue is full because polar_stall has backed up the whole pipeline. The angle is
// in units of pi/32768 with -32768 meaning -pi; points on the x axis bypass the rotations.
`timescale 1ns / 1ps

module cartesian_to_polar_core
    import c2p_pkg::*;
#(
    parameter int ITERATIONS = ITERATIONS_DEF
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   point_valid,
    output logic   point_stall,
    input  point_t point,
    output logic   polar_valid,
    input  logic   polar_stall,
    output polar_t polar
);

    work_t front_item;
    work_t queue_item;
    logic  queue_valid;
    logic  back_stall;

    // Classification and pre-rotation
    c2p_front u_front (
        .point (point),
        .item  (front_item)
    );

    // Decoupling queue
    c2p_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (point_valid),
        .wr_item  (front_item),
        .wr_stall (point_stall),
        .rd_valid (queue_valid),
        .rd_item  (queue_item),
        .rd_stall (back_stall)
    );

    // Rotation pipeline and gain correction
    c2p_back #(
        .ITERATIONS (ITERATIONS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (queue_valid),
        .in_item   (queue_item),
        .in_stall  (back_stall),
        .out_valid (polar_valid),
        .out_item  (polar),
        .out_stall (polar_stall)
    );

endmodule

// File: design/c2p_front.sv
// Front end: classifies a request and pre-rotates left-half-plane points by pi.
`timescale 1ns / 1ps

module c2p_front
    import c2p_pkg::*;
(
    input  point_t point,
    output work_t  item
);

    logic signed [DATA_WIDTH-1:0] xi;
    logic signed [DATA_WIDTH-1:0] yi;
    logic signed [DATA_WIDTH-1:0] x_fold;
    logic signed [DATA_WIDTH-1:0] y_fold;
    logic                         x_neg;
    logic                         y_zero;

    assign xi     = DATA_WIDTH'(point.x_coord);
    assign yi     = DATA_WIDTH'(point.y_coord);
    assign x_neg  = point.x_coord[COORD_WIDTH-1];
    assign y_zero = (point.y_coord == '0);

    // Turn the point by pi when it lies left of the y axis
    assign x_fold = x_neg ? -xi : xi;
    assign y_fold = x_neg ? -yi : yi;

    // On the x axis the result is known: |x| and 0 or -pi
    always_comb
    begin
        item.special = y_zero;
        item.z       = x_neg ? ANGLE_PI : ANGLE_ZERO;
        if (y_zero)
        begin
            item.x = x_fold;
            item.y = '0;
        end
        else
        begin
            item.x = x_fold <<< CORDIC_FRAC;
            item.y = y_fold <<< CORDIC_FRAC;
        end
    end

endmodule

// File: design/c2p_queue.sv
// Short queue that decouples the front end from the rotation pipeline.
`timescale 1ns / 1ps

module c2p_queue
    import c2p_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  wr_valid,
    input  work_t wr_item,
    output logic  wr_stall,
    output logic  rd_valid,
    output work_t rd_item,
    input  logic  rd_stall
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    work_t            mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push;
    logic             pop;

    assign wr_stall = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_item  = mem_reg[rd_ptr_reg];
    assign push     = wr_valid && !wr_stall;
    assign pop      = rd_valid && !rd_stall;

    // Pointer wrap and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= wr_item;
    end

endmodule

// File: design/c2p_stage.sv
// One registered micro-rotation of the vectoring pipeline.
`timescale 1ns / 1ps

module c2p_stage
    import c2p_pkg::*;
#(
    parameter int SHIFT = 0
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    input  work_t in_item,
    output logic  in_stall,
    output logic  out_valid,
    output work_t out_item,
    input  logic  out_stall
);

    localparam logic [ANGLE_WIDTH-1:0] ATAN = atan_entry(5'(SHIFT));

    logic                         valid_reg;
    work_t                        item_reg, item_next;
    logic signed [DATA_WIDTH-1:0] x_sh;
    logic signed [DATA_WIDTH-1:0] y_sh;

    assign in_stall  = valid_reg && out_stall;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    assign x_sh = $signed(in_item.x) >>> SHIFT;
    assign y_sh = $signed(in_item.y) >>> SHIFT;

    // Rotate toward the x axis; axis points pass unchanged
    always_comb
    begin
        item_next = in_item;
        if (!in_item.special)
        begin
            if (!in_item.y[DATA_WIDTH-1])
            begin
                item_next.x = in_item.x + y_sh;
                item_next.y = in_item.y - x_sh;
                item_next.z = in_item.z + ATAN;
            end
            else
            begin
                item_next.x = in_item.x - y_sh;
                item_next.y = in_item.y + x_sh;
                item_next.z = in_item.z - ATAN;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (!in_stall)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
            item_reg <= item_next;
    end

endmodule

// File: design/c2p_back.sv
// Back end: rotation pipeline, gain correction and the result register.
`timescale 1ns / 1ps

module c2p_back
    import c2p_pkg::*;
#(
    parameter int ITERATIONS = ITERATIONS_DEF
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    input  work_t  in_item,
    output logic   in_stall,
    output logic   out_valid,
    output polar_t out_item,
    input  logic   out_stall
);

    // Magnitude product split into a low 32-bit part and a narrow high part
    localparam int MW   = DATA_WIDTH - 1;
    localparam int MHW  = (MW > 32) ? (MW - 32) : 1;
    localparam int MEXT = 32 + MHW;
    localparam int HW   = MHW + 32;
    localparam int SW   = HW + 32;
    localparam logic [SW-1:0] MAG_BIAS = SW'(1) << (MAG_SHIFT - 1);

    logic  s_valid [ITERATIONS+1];
    work_t s_item  [ITERATIONS+1];
    logic  s_stall [ITERATIONS+1];

    assign s_valid[0] = in_valid;
    assign s_item[0]  = in_item;
    assign in_stall   = s_stall[0];

    // Unrolled micro-rotations, one register each
    for (genvar k = 0; k < ITERATIONS; k++)
    begin : g_stage
        c2p_stage #(
            .SHIFT (k)
        ) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (s_valid[k]),
            .in_item   (s_item[k]),
            .in_stall  (s_stall[k]),
            .out_valid (s_valid[k+1]),
            .out_item  (s_item[k+1]),
            .out_stall (s_stall[k+1])
        );
    end

    // Gain multiply stage
    logic                        g_valid_reg;
    logic                        g_special_reg;
    logic [MAG_WIDTH-1:0]        g_smag_reg;
    logic [63:0]                 g_lo_reg, g_lo_next;
    logic [HW-1:0]               g_hi_reg, g_hi_next;
    logic [OUT_ANGLE_WIDTH-1:0]  g_angle_reg;
    logic                        g_stall;
    work_t                       last;
    logic                        x_pos;
    logic [MEXT-1:0]             m_ext;
    logic [ANGLE_WIDTH-1:0]      z_rnd;

    assign last   = s_item[ITERATIONS];
    assign x_pos  = !last.x[DATA_WIDTH-1] && (last.x != '0);
    assign m_ext  = x_pos ? MEXT'(last.x[MW-1:0]) : '0;
    assign g_lo_next = 64'(m_ext[31:0]) * 64'(GAIN_Q31);
    assign g_hi_next = HW'(m_ext[MEXT-1:32]) * HW'(GAIN_Q31);
    assign z_rnd  = last.z + ANGLE_ROUND;

    logic out_valid_reg;
    polar_t out_item_reg, out_item_next;

    assign g_stall = g_valid_reg && out_stall && out_valid_reg;
    assign s_stall[ITERATIONS] = g_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            g_valid_reg <= 1'b0;
        else if (!g_stall)
            g_valid_reg <= s_valid[ITERATIONS];
    end

    always_ff @(posedge clk)
    begin
        if (!g_stall && s_valid[ITERATIONS])
        begin
            g_special_reg <= last.special;
            g_smag_reg    <= last.x[MAG_WIDTH-1:0];
            g_lo_reg      <= g_lo_next;
            g_hi_reg      <= g_hi_next;
            g_angle_reg   <= z_rnd[ANGLE_WIDTH-1 -: OUT_ANGLE_WIDTH];
        end
    end

    // Rounded magnitude and result register
    logic            o_stall;
    logic [SW-1:0]   mag_sum;

    assign o_stall  = out_valid_reg && out_stall;
    assign mag_sum  = {g_hi_reg, 32'b0} + SW'(g_lo_reg) + MAG_BIAS;

    always_comb
    begin
        out_item_next.angle = g_angle_reg;
        if (g_special_reg)
            out_item_next.magnitude = g_smag_reg;
        else
            out_item_next.magnitude = mag_sum[MAG_SHIFT +: MAG_WIDTH];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (!o_stall)
            out_valid_reg <= g_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (!o_stall && g_valid_reg)
            out_item_reg <= out_item_next;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

// File: design/c2p_checker.sv
// Port-level checks for the cartesian-to-polar core and their binding.
`timescale 1ns / 1ps

module c2p_checker
    import c2p_pkg::*;
#(
    parameter int ITERATIONS = ITERATIONS_DEF
)
(
    input logic   clk,
    input logic   rst_n,
    input logic   point_valid,
    input logic   point_stall,
    input point_t point,
    input logic   polar_valid,
    input logic   polar_stall,
    input polar_t polar
);

    localparam int CAPACITY = QUEUE_DEPTH + ITERATIONS + 2;
    localparam int CNT_W    = $clog2(CAPACITY + 2);

    logic [CNT_W-1:0] pending_reg, pending_next;
    logic             in_acc;
    logic             out_acc;

    assign in_acc  = point_valid && !point_stall;
    assign out_acc = polar_valid && !polar_stall;

    // Requests accepted but not yet delivered
    always_comb
    begin
        pending_next = pending_reg;
        if (in_acc && !out_acc)
            pending_next = pending_reg + 1'b1;
        else if (out_acc && !in_acc)
            pending_next = pending_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pending_reg <= '0;
        else
            pending_reg <= pending_next;
    end

    // No result without an outstanding request
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        polar_valid |-> (pending_reg != '0))
        else $error("result shown with no request outstanding");

    // Never more in flight than the queue and pipeline can hold
    a_capacity: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= CNT_W'(CAPACITY))
        else $error("more requests in flight than storage allows");

    // Input backpressure only with at least a queue's depth of requests outstanding
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        point_stall |-> (pending_reg >= CNT_W'(QUEUE_DEPTH)))
        else $error("point_stall without a full queue");

    // A stalled result holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (polar_valid && polar_stall) |=> (polar_valid && $stable(polar)))
        else $error("stalled result changed or dropped");

endmodule

bind cartesian_to_polar_core c2p_checker #(
    .ITERATIONS (ITERATIONS)
) u_c2p_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .point_valid (point_valid),
    .point_stall (point_stall),
    .point       (point),
    .polar_valid (polar_valid),
    .polar_stall (polar_stall),
    .polar       (polar)
);
